/* hdl/loop_interval_window_stats_top_assert.svh */
// Assertion macros for the loop interval statistics block.
// Used by loop_interval_window_stats_top; needs clk and rst in scope.
`ifndef LOOP_INTERVAL_WINDOW_STATS_TOP_ASSERT_SVH
`define LOOP_INTERVAL_WINDOW_STATS_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LIWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define LIWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/liws_pkg.sv */
// Package for the loop interval statistics block: widths, register indexes.
// No dependencies.
package liws_pkg;

  localparam int TS_BITS_DEF = 32;
  localparam int IV_W        = 32;
  localparam int SUM_W       = 48;
  localparam int WL_W        = 16;
  localparam int EVT_W       = 17;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP_COUNT  = 1'd1;

  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 16'd30;
  localparam logic [CFG_W-1:0] WARMUP_COUNT_RST  = 16'd10;

  localparam logic [EVT_W-1:0] EVT_MAX = '1;

endpackage

/* hdl/liws_if.sv */
// Item channels of the loop interval statistics block: event in, result out.
// Depends on liws_pkg.
interface liws_in_if import liws_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            mode;
  logic [31:0]     timestamp_us;

  modport source (output valid, mode, timestamp_us, input ready);
  modport sink   (input valid, mode, timestamp_us, output ready);
endinterface

interface liws_out_if import liws_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IV_W-1:0] interval_us;
  logic [IV_W-1:0] window_min_us;
  logic [IV_W-1:0] window_max_us;
  logic [IV_W-1:0] window_avg_us;
  logic            window_done;

  modport source (output valid, interval_us, window_min_us, window_max_us,
                  window_avg_us, window_done, input ready);
  modport sink   (input valid, interval_us, window_min_us, window_max_us,
                  window_avg_us, window_done, output ready);
endinterface

/* hdl/liws_div.sv */
// Restoring divider, one quotient bit per cycle: window sum / window length.
// Depends on liws_pkg.
module liws_div import liws_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [WL_W-1:0]  divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] dvd;
  logic [WL_W-1:0]  dsr;
  logic [WL_W-1:0]  rem;
  logic [WL_W:0]    rem_sh;
  logic             ge;

  always_comb begin
    rem_sh = {rem, dvd[SUM_W-1]};
    ge     = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[SUM_W-2:0], ge};
      rem <= ge ? WL_W'(rem_sh - {1'b0, dsr}) : WL_W'(rem_sh);
    end
  end

  assign quotient = dvd;

endmodule

/* hdl/loop_interval_window_stats_top.sv */
// Channel | dir | payload
// evt     | in  | mode, timestamp_us
// rslt    | out | interval_us, window_min_us, window_max_us, window_avg_us, window_done
// A start item only stores its timestamp. An end item passes DIFF, UPD and PUSH, and DIV too
// when it closes a window (the divider takes one quotient bit a cycle over the 48-bit sum).
// evt.ready is high only while the sequencer idles; a finished result waits in
// the output register and the next item may enter meanwhile.
// Synchronous reset: registers to reset values, all window state to zero.
// Depends on liws_pkg, liws_if, liws_div and the assertion macro header.
`include "loop_interval_window_stats_top_assert.svh"

module loop_interval_window_stats_top import liws_pkg::*; #(
  parameter int TIMESTAMP_BITS = TS_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  liws_in_if.sink              evt,
  liws_out_if.source           rslt
);

  localparam int TB = TIMESTAMP_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIFF = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_PUSH = 3'd4;

  logic [2:0]       st;
  logic [WL_W-1:0]  window_length;
  logic [WL_W-1:0]  warmup_count;
  logic [TB-1:0]    prev_timestamp;
  logic [TB-1:0]    ts_r;
  logic [EVT_W-1:0] event_counter;
  logic [WL_W-1:0]  sample_count;
  logic [IV_W-1:0]  run_min;
  logic [IV_W-1:0]  run_max;
  logic [SUM_W-1:0] run_sum;
  logic [IV_W-1:0]  last_avg;
  logic [IV_W-1:0]  iv;
  logic [IV_W-1:0]  res_iv;
  logic             res_done;

  logic             out_valid;
  logic [IV_W-1:0]  o_iv;
  logic [IV_W-1:0]  o_min;
  logic [IV_W-1:0]  o_max;
  logic [IV_W-1:0]  o_avg;
  logic             o_done;

  logic [63:0]      ts_wide;
  logic [TB-1:0]    ts_in;
  logic [TB-1:0]    diff;
  logic [63:0]      diff_wide;
  logic [IV_W-1:0]  iv_calc;
  logic             warm;
  logic [WL_W-1:0]  wl_eff;
  logic [WL_W-1:0]  sc_new;
  logic [SUM_W-1:0] sum_new;
  logic             win_end;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_q;
  logic             accept;
  logic             push_go;

  always_comb begin
    ts_wide   = 64'(evt.timestamp_us);
    ts_in     = ts_wide[TB-1:0];
    diff      = ts_r - prev_timestamp;
    diff_wide = 64'(diff);
    iv_calc   = (|diff_wide[63:32]) ? '1 : diff_wide[31:0];
    warm      = event_counter <= EVT_W'(warmup_count);
    wl_eff    = (window_length == '0) ? WL_W'(1) : window_length;
    sc_new    = sample_count + 1'b1;
    sum_new   = ((sample_count == '0) ? '0 : run_sum) + SUM_W'(iv);
    win_end   = (sc_new >= wl_eff) || (sc_new == '0);
    div_start = (st == ST_UPD) && !warm && win_end;
    accept    = evt.valid && evt.ready;
    push_go   = (st == ST_PUSH) && (!out_valid || rslt.ready);
  end

  assign evt.ready = (st == ST_IDLE);

  liws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_new),
    .divisor  (wl_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RST;
      warmup_count  <= WARMUP_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data;
        REG_WARMUP_COUNT:  warmup_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= ST_IDLE;
      prev_timestamp <= '0;
      event_counter  <= '0;
      sample_count   <= '0;
      run_min        <= '0;
      run_max        <= '0;
      run_sum        <= '0;
      last_avg       <= '0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (accept) begin
            if (evt.mode) begin
              ts_r <= ts_in;
              st   <= ST_DIFF;
            end else begin
              prev_timestamp <= ts_in;
            end
          end
        end
        ST_DIFF: begin
          iv             <= iv_calc;
          prev_timestamp <= ts_r;
          if (event_counter != EVT_MAX) event_counter <= event_counter + 1'b1;
          st <= ST_UPD;
        end
        ST_UPD: begin
          if (warm) begin
            sample_count <= '0;
            run_sum      <= '0;
            last_avg     <= '0;
            run_min      <= '0;
            run_max      <= '0;
            res_iv       <= '0;
            res_done     <= 1'b0;
            st           <= ST_PUSH;
          end else begin
            res_iv <= iv;
            if (sample_count == '0) begin
              run_min <= iv;
              run_max <= iv;
            end else begin
              if (iv < run_min) run_min <= iv;
              if (iv > run_max) run_max <= iv;
            end
            if (win_end) begin
              sample_count <= '0;
              run_sum      <= '0;
              res_done     <= 1'b1;
              st           <= ST_DIV;
            end else begin
              sample_count <= sc_new;
              run_sum      <= sum_new;
              res_done     <= 1'b0;
              st           <= ST_PUSH;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            last_avg <= (|div_q[SUM_W-1:IV_W]) ? '1 : div_q[IV_W-1:0];
            st       <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push_go) st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_go) begin
      out_valid <= 1'b1;
    end else if (rslt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_go) begin
      o_iv   <= res_iv;
      o_min  <= run_min;
      o_max  <= run_max;
      o_avg  <= last_avg;
      o_done <= res_done;
    end
  end

  assign rslt.valid         = out_valid;
  assign rslt.interval_us   = o_iv;
  assign rslt.window_min_us = o_min;
  assign rslt.window_max_us = o_max;
  assign rslt.window_avg_us = o_avg;
  assign rslt.window_done   = o_done;

  `LIWS_ASSERT_NOW(a_min_le_max, 1'b1, run_min <= run_max, "window min above max")
  `LIWS_ASSERT_NOW(a_empty_sum, sample_count == '0, run_sum == '0, "sum left in empty window")
  `LIWS_ASSERT_NOW(a_done_clear, (st == ST_PUSH) && res_done, (sample_count == '0) && (run_sum == '0), "window closed without clearing")
  `LIWS_ASSERT_NEXT(a_div_wait, (st == ST_DIV) && !div_done, st == ST_DIV, "left divide before quotient")
  `LIWS_ASSERT_NOW(a_div_state, div_done, st == ST_DIV, "quotient outside divide state")

endmodule
